// File: rtl/tlbpt_pkg.sv
// Shared types and constants for the TLB and page table translator.
package tlbpt_pkg;

   // Address layout and defaults.
   localparam int unsigned VA_W             = 16;
   localparam int unsigned PAGE_W           = 8;
   localparam int unsigned FRAME_W          = 8;
   localparam int unsigned FRAME_CNT_W      = 9;
   localparam int unsigned FAULT_CNT_W      = 9;
   localparam int unsigned CNT_W            = 32;
   localparam int unsigned PAGE_SPACE       = 256;
   localparam int unsigned TLB_ENTRIES_DEF  = 16;
   localparam int unsigned PAGE_COUNT_DEF   = 256;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_RESOLVE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/tlbpt_ctrl.sv
// Controller state machine that sequences one translation at a time.
module tlbpt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  tlbpt_pkg::dp_status_type status,
   output tlbpt_pkg::ctrl_cmd_type  cmd
);

   tlbpt_pkg::state_type state_ff;
   tlbpt_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlbpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: take an item, wait for the page table read, then resolve.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlbpt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tlbpt_pkg::ST_LOOKUP;
            end
         end
         tlbpt_pkg::ST_LOOKUP: begin
            state_in = tlbpt_pkg::ST_RESOLVE;
         end
         tlbpt_pkg::ST_RESOLVE: begin
            if (status.out_free) begin
               state_in = tlbpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tlbpt_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs: the input side is open only while idle.
   always_comb begin
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         tlbpt_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         tlbpt_pkg::ST_LOOKUP: begin
            req_stall = 1'b1;
         end
         tlbpt_pkg::ST_RESOLVE: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// File: rtl/tlbpt_datapath.sv
// Datapath: TLB registers, page table memory, frame allocator, counters and result register.
module tlbpt_datapath #(
   parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
   parameter int unsigned PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tlbpt_pkg::ctrl_cmd_type           cmd,
   output tlbpt_pkg::dp_status_type          status,
   input  logic [tlbpt_pkg::VA_W-1:0]        req_virtual_address,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tlbpt_pkg::VA_W-1:0]        rsp_physical_address,
   output logic [tlbpt_pkg::FRAME_W-1:0]     rsp_frame_number,
   output logic                              rsp_tlb_hit,
   output logic                              rsp_page_fault,
   output logic [tlbpt_pkg::CNT_W-1:0]       rsp_hit_count,
   output logic [tlbpt_pkg::FAULT_CNT_W-1:0] rsp_fault_count,
   output logic [tlbpt_pkg::CNT_W-1:0]       rsp_translated_count
);

   localparam int unsigned FP_W     = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int unsigned PT_DEPTH = (PAGE_COUNT < tlbpt_pkg::PAGE_SPACE) ?
                                      PAGE_COUNT : tlbpt_pkg::PAGE_SPACE;
   localparam int unsigned PT_IDX_W = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
   localparam logic [FP_W-1:0] FP_LAST = FP_W'(TLB_ENTRIES - 1);
   localparam logic [tlbpt_pkg::FRAME_CNT_W-1:0] FRAME_LIMIT =
      tlbpt_pkg::FRAME_CNT_W'(tlbpt_pkg::PAGE_SPACE);
   localparam logic [tlbpt_pkg::FAULT_CNT_W-1:0] FAULT_MAX = '1;
   localparam logic [tlbpt_pkg::CNT_W-1:0]       CNT_MAX   = '1;

   // Captured address.
   logic [tlbpt_pkg::VA_W-1:0]    va_ff;
   logic [tlbpt_pkg::PAGE_W-1:0]  page;
   logic [tlbpt_pkg::PAGE_W-1:0]  offset;
   logic [PT_IDX_W-1:0]           pidx;
   logic [PT_IDX_W-1:0]           pidx_table [tlbpt_pkg::PAGE_SPACE];

   // TLB storage.
   logic [tlbpt_pkg::PAGE_W-1:0]  tag_ff   [TLB_ENTRIES];
   logic [tlbpt_pkg::FRAME_W-1:0] tframe_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0]        tvalid_ff;
   logic [FP_W-1:0]               fill_ptr_ff;

   // Page table storage.
   logic [tlbpt_pkg::FRAME_W-1:0] pt_mem [PT_DEPTH];
   logic [tlbpt_pkg::FRAME_W-1:0] pt_rdata_ff;
   logic [PT_DEPTH-1:0]           page_valid_ff;

   // Allocator and counters.
   logic [tlbpt_pkg::FRAME_CNT_W-1:0] next_free_ff;
   logic [tlbpt_pkg::CNT_W-1:0]       hits_ff;
   logic [tlbpt_pkg::FAULT_CNT_W-1:0] faults_ff;
   logic [tlbpt_pkg::CNT_W-1:0]       trans_ff;
   logic [tlbpt_pkg::CNT_W-1:0]       hits_in;
   logic [tlbpt_pkg::FAULT_CNT_W-1:0] faults_in;
   logic [tlbpt_pkg::CNT_W-1:0]       trans_in;

   // Lookup results.
   logic                          hit;
   logic [tlbpt_pkg::FRAME_W-1:0] hit_frame;
   logic                          fault;
   logic [tlbpt_pkg::FRAME_W-1:0] frame;

   // Result register.
   logic                              rsp_valid_ff;
   logic [tlbpt_pkg::VA_W-1:0]        rsp_pa_ff;
   logic [tlbpt_pkg::FRAME_W-1:0]     rsp_frame_ff;
   logic                              rsp_hit_ff;
   logic                              rsp_fault_ff;
   logic [tlbpt_pkg::CNT_W-1:0]       rsp_hits_ff;
   logic [tlbpt_pkg::FAULT_CNT_W-1:0] rsp_faults_ff;
   logic [tlbpt_pkg::CNT_W-1:0]       rsp_trans_ff;

   // Constant table that folds a page number onto the page table depth.
   for (genvar g = 0; g < tlbpt_pkg::PAGE_SPACE; g++) begin : g_pidx
      assign pidx_table[g] = PT_IDX_W'(g % PAGE_COUNT);
   end

   assign page   = va_ff[tlbpt_pkg::VA_W-1:tlbpt_pkg::VA_W-tlbpt_pkg::PAGE_W];
   assign offset = va_ff[tlbpt_pkg::VA_W-tlbpt_pkg::PAGE_W-1:0];
   assign pidx   = pidx_table[page];

   // Address capture when an item is taken.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         va_ff <= req_virtual_address;
      end
   end

   // TLB search; the lowest-numbered matching entry wins.
   always_comb begin
      hit       = 1'b0;
      hit_frame = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tvalid_ff[i] && (tag_ff[i] == page)) begin
            hit       = 1'b1;
            hit_frame = tframe_ff[i];
         end
      end
   end

   // Frame selection: TLB, then page table, then a newly assigned frame.
   assign fault = !hit && !page_valid_ff[pidx];
   always_comb begin
      if (hit) begin
         frame = hit_frame;
      end else if (fault) begin
         frame = next_free_ff[tlbpt_pkg::FRAME_W-1:0];
      end else begin
         frame = pt_rdata_ff;
      end
   end

   // Page table memory with registered read.
   always_ff @(posedge clock) begin
      if (cmd.commit && fault) begin
         pt_mem[pidx] <= next_free_ff[tlbpt_pkg::FRAME_W-1:0];
      end
      pt_rdata_ff <= pt_mem[pidx];
   end

   // Page valid bits and frame allocator.
   always_ff @(posedge clock) begin
      if (reset) begin
         page_valid_ff <= '0;
         next_free_ff  <= '0;
      end else if (cmd.commit && fault) begin
         page_valid_ff[pidx] <= 1'b1;
         if (next_free_ff < FRAME_LIMIT) begin
            next_free_ff <= next_free_ff + 1'b1;
         end
      end
   end

   // TLB refill at the FIFO pointer on a miss.
   always_ff @(posedge clock) begin
      if (reset) begin
         tvalid_ff   <= '0;
         fill_ptr_ff <= '0;
      end else if (cmd.commit && !hit) begin
         tvalid_ff[fill_ptr_ff] <= 1'b1;
         fill_ptr_ff <= (fill_ptr_ff == FP_LAST) ? '0 : fill_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && !hit) begin
         tag_ff[fill_ptr_ff]    <= page;
         tframe_ff[fill_ptr_ff] <= frame;
      end
   end

   // Saturating counters.
   always_comb begin
      hits_in   = (hit && (hits_ff != CNT_MAX)) ? hits_ff + 1'b1 : hits_ff;
      faults_in = (fault && (faults_ff != FAULT_MAX)) ? faults_ff + 1'b1 : faults_ff;
      trans_in  = (trans_ff != CNT_MAX) ? trans_ff + 1'b1 : trans_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff   <= '0;
         faults_ff <= '0;
         trans_ff  <= '0;
      end else if (cmd.commit) begin
         hits_ff   <= hits_in;
         faults_ff <= faults_in;
         trans_ff  <= trans_in;
      end
   end

   // Result register; the next item may enter while this one waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_pa_ff     <= {frame, offset};
         rsp_frame_ff  <= frame;
         rsp_hit_ff    <= hit;
         rsp_fault_ff  <= fault;
         rsp_hits_ff   <= hits_in;
         rsp_faults_ff <= faults_in;
         rsp_trans_ff  <= trans_in;
      end
   end

   assign status.out_free      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_pa_ff;
   assign rsp_frame_number     = rsp_frame_ff;
   assign rsp_tlb_hit          = rsp_hit_ff;
   assign rsp_page_fault       = rsp_fault_ff;
   assign rsp_hit_count        = rsp_hits_ff;
   assign rsp_fault_count      = rsp_faults_ff;
   assign rsp_translated_count = rsp_trans_ff;

   // A new frame is never assigned for a page that hit in the TLB.
   a_fault_not_hit: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && fault) |-> !hit)
      else $error("page fault flagged on a TLB hit");

   // The allocator never runs past the frame space.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= FRAME_LIMIT)
      else $error("next free frame out of range");

   // A committed item always shows up in the result register.
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("result lost after commit");

   // Each fault advances the fault count by exactly one.
   a_fault_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && fault) |=> (faults_ff == $past(faults_ff) + 1'b1))
      else $error("fault count did not advance");

endmodule

// File: rtl/tlb_page_table_translator_top.sv
// Top level of the TLB and demand-paged page table translator.
//
//   Channel | Direction | Ports                                  | Handshake
//   req     | in        | req_virtual_address                    | req_valid / req_stall
//   rsp     | out       | rsp_physical_address .. rsp_*_count    | rsp_valid / rsp_stall
//
// An item steps through accept, page table read, then resolve and commit; the
// page table's registered read port calls for the read step. A new item enters
// after the last has committed. A result waits in the output register while the
// next item is taken. Reset clears the TLB and page valid bits at once, with no
// clearing pass. A stalled result holds the resolve step until the register frees.
module tlb_page_table_translator_top #(
   parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
   parameter int unsigned PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tlbpt_pkg::VA_W-1:0]        req_virtual_address,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tlbpt_pkg::VA_W-1:0]        rsp_physical_address,
   output logic [tlbpt_pkg::FRAME_W-1:0]     rsp_frame_number,
   output logic                              rsp_tlb_hit,
   output logic                              rsp_page_fault,
   output logic [tlbpt_pkg::CNT_W-1:0]       rsp_hit_count,
   output logic [tlbpt_pkg::FAULT_CNT_W-1:0] rsp_fault_count,
   output logic [tlbpt_pkg::CNT_W-1:0]       rsp_translated_count
);

   tlbpt_pkg::ctrl_cmd_type  cmd;
   tlbpt_pkg::dp_status_type status;

   // Sequencer.
   tlbpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Translation datapath.
   tlbpt_datapath #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .PAGE_COUNT  (PAGE_COUNT)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_virtual_address  (req_virtual_address),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_physical_address (rsp_physical_address),
      .rsp_frame_number     (rsp_frame_number),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_hit_count        (rsp_hit_count),
      .rsp_fault_count      (rsp_fault_count),
      .rsp_translated_count (rsp_translated_count)
   );

endmodule
